[rtl/dcb_pkg.sv]
// Shared types and codes for the draw command batcher.
// Used by every module of the block; depends on nothing.
package dcb_pkg;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_NODE   = 2'd1;
  localparam logic [1:0] KIND_RENDER = 2'd2;

  localparam logic [3:0] CMD_FILL_RECT    = 4'd0;
  localparam logic [3:0] CMD_FILL_ROUNDED = 4'd1;
  localparam logic [3:0] CMD_STROKE       = 4'd2;
  localparam logic [3:0] CMD_IMAGE        = 4'd3;
  localparam logic [3:0] CMD_MESH         = 4'd4;
  localparam logic [3:0] CMD_GLYPH        = 4'd5;
  localparam logic [3:0] CMD_PUSH_CLIP    = 4'd6;
  localparam logic [3:0] CMD_POP_CLIP     = 4'd7;
  localparam logic [3:0] CMD_PUSH_OPACITY = 4'd8;
  localparam logic [3:0] CMD_POP_OPACITY  = 4'd9;
  localparam logic [3:0] CMD_PUSH_XFORM   = 4'd10;
  localparam logic [3:0] CMD_POP_XFORM    = 4'd11;

  localparam logic [1:0] PIPE_RECT  = 2'd0;
  localparam logic [1:0] PIPE_IMAGE = 2'd1;
  localparam logic [1:0] PIPE_MESH  = 2'd2;
  localparam logic [1:0] PIPE_GLYPH = 2'd3;

  localparam logic [31:0] RES_FILL   = 32'd0;
  localparam logic [31:0] RES_STROKE = 32'd1;

  localparam logic REG_BATCHING = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam logic [15:0] CAPACITY_RESET  = 16'd256;
  localparam logic [63:0] SIGNATURE_RESET = 64'd1;

  localparam logic STATUS_PACKET  = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [2:0] {
    OP_FRAME,
    OP_NODE,
    OP_BARRIER,
    OP_DRAW,
    OP_INVALID
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [1:0]  pipeline;
    logic [31:0] resource;
    logic [31:0] node;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic        status;
    logic [1:0]  pipeline;
    logic [31:0] resource;
    logic [31:0] packet_node;
    logic [63:0] packet_signature;
    logic [31:0] packet_order;
    logic        merged;
    logic [31:0] batch_index;
    logic [31:0] batch_first_packet;
    logic [15:0] batch_size;
    logic [31:0] barrier_total;
    logic [31:0] merged_total;
  } result_t;

endpackage

[rtl/dcb_front.sv]
// Front end: accepts items and classifies them into queue entries.
// Depends on dcb_pkg.
module dcb_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [3:0]           command_kind,
  input  logic [31:0]          resource_handle,
  input  logic [31:0]          node_ident,
  input  dcb_pkg::queue_status_t q_status,
  output logic                 q_push,
  output dcb_pkg::entry_t      q_entry
);

  logic keep;

  assign in_ready = !q_status.full;

  always_comb begin
    keep              = 1'b1;
    q_entry.op        = dcb_pkg::OP_INVALID;
    q_entry.pipeline  = dcb_pkg::PIPE_RECT;
    q_entry.resource  = dcb_pkg::RES_FILL;
    q_entry.node      = node_ident;
    unique case (kind)
      dcb_pkg::KIND_FRAME: q_entry.op = dcb_pkg::OP_FRAME;
      dcb_pkg::KIND_NODE:  q_entry.op = dcb_pkg::OP_NODE;
      dcb_pkg::KIND_RENDER: begin
        unique case (command_kind) inside
          dcb_pkg::CMD_FILL_RECT, dcb_pkg::CMD_FILL_ROUNDED: begin
            q_entry.op = dcb_pkg::OP_DRAW;
          end
          dcb_pkg::CMD_STROKE: begin
            q_entry.op       = dcb_pkg::OP_DRAW;
            q_entry.resource = dcb_pkg::RES_STROKE;
          end
          dcb_pkg::CMD_IMAGE: begin
            q_entry.op       = dcb_pkg::OP_DRAW;
            q_entry.pipeline = dcb_pkg::PIPE_IMAGE;
            q_entry.resource = resource_handle;
          end
          dcb_pkg::CMD_MESH: begin
            q_entry.op       = dcb_pkg::OP_DRAW;
            q_entry.pipeline = dcb_pkg::PIPE_MESH;
            q_entry.resource = resource_handle;
          end
          dcb_pkg::CMD_GLYPH: begin
            q_entry.op       = dcb_pkg::OP_DRAW;
            q_entry.pipeline = dcb_pkg::PIPE_GLYPH;
            q_entry.resource = resource_handle;
          end
          dcb_pkg::CMD_PUSH_CLIP, dcb_pkg::CMD_POP_CLIP,
          dcb_pkg::CMD_PUSH_OPACITY, dcb_pkg::CMD_POP_OPACITY,
          dcb_pkg::CMD_PUSH_XFORM, dcb_pkg::CMD_POP_XFORM: begin
            q_entry.op = dcb_pkg::OP_BARRIER;
          end
          default: q_entry.op = dcb_pkg::OP_INVALID;
        endcase
      end
      default: keep = 1'b0;  // unused kind is dropped
    endcase
  end

  assign q_push = in_valid && in_ready && keep;

endmodule

[rtl/dcb_queue.sv]
// Two-entry queue between the classifier and the batching back end.
// Depends on dcb_pkg.
module dcb_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  dcb_pkg::entry_t        push_entry,
  input  logic                   pop,
  output dcb_pkg::entry_t        head,
  output dcb_pkg::queue_status_t status
);

  dcb_pkg::entry_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign head         = slots[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

[rtl/dcb_back.sv]
// Back end: frame state, batch matching, counters and the result register.
// Depends on dcb_pkg.
module dcb_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data,
  input  dcb_pkg::entry_t        head,
  input  dcb_pkg::queue_status_t q_status,
  output logic                   pop,
  output logic                   res_valid,
  input  logic                   res_ready,
  output dcb_pkg::result_t       res
);

  logic        batching_enabled;
  logic [15:0] packet_capacity;

  logic [63:0] signature;
  logic [31:0] next_order;
  logic        batch_open;
  logic [1:0]  open_pipeline;
  logic [31:0] open_resource;
  logic [63:0] open_signature;
  logic [31:0] open_first;
  logic [15:0] open_count;
  logic [31:0] batches_made;
  logic [31:0] barriers;
  logic [31:0] merges;
  logic [31:0] current_node;
  logic        failed;

  logic        merge_hit;
  logic [15:0] count_next;
  logic [31:0] merges_next;
  logic [31:0] batches_next;

  assign pop = !q_status.empty && (!res_valid || res_ready);

  assign merge_hit = batch_open && batching_enabled && (open_count < packet_capacity) &&
                     (open_pipeline == head.pipeline) && (open_resource == head.resource) &&
                     (open_signature == signature);

  assign count_next   = merge_hit ? open_count + 16'd1 : 16'd1;
  assign merges_next  = merge_hit ? merges + 32'd1 : merges;
  assign batches_next = merge_hit ? batches_made : batches_made + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      batching_enabled <= 1'b1;
      packet_capacity  <= dcb_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == dcb_pkg::REG_BATCHING) batching_enabled <= cfg_data[0];
      else packet_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (pop && head.op == dcb_pkg::OP_FRAME)) begin
      signature      <= dcb_pkg::SIGNATURE_RESET;
      next_order     <= 32'd0;
      batch_open     <= 1'b0;
      open_pipeline  <= dcb_pkg::PIPE_RECT;
      open_resource  <= 32'd0;
      open_signature <= dcb_pkg::SIGNATURE_RESET;
      open_first     <= 32'd0;
      open_count     <= 16'd0;
      batches_made   <= 32'd0;
      barriers       <= 32'd0;
      merges         <= 32'd0;
      current_node   <= 32'd0;
      failed         <= 1'b0;
    end else if (pop && !failed) begin
      unique case (head.op)
        dcb_pkg::OP_NODE: begin
          current_node <= head.node;
          if (batch_open) begin
            barriers   <= barriers + 32'd1;
            signature  <= signature + 64'd1;
            batch_open <= 1'b0;
          end
        end
        dcb_pkg::OP_BARRIER: begin
          barriers   <= barriers + 32'd1;
          signature  <= signature + 64'd1;
          batch_open <= 1'b0;
        end
        dcb_pkg::OP_DRAW: begin
          next_order   <= next_order + 32'd1;
          open_count   <= count_next;
          merges       <= merges_next;
          batches_made <= batches_next;
          if (!merge_hit) begin
            batch_open     <= 1'b1;
            open_pipeline  <= head.pipeline;
            open_resource  <= head.resource;
            open_signature <= signature;
            open_first     <= next_order;
          end
        end
        dcb_pkg::OP_INVALID: failed <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && !failed &&
                 (head.op == dcb_pkg::OP_DRAW || head.op == dcb_pkg::OP_INVALID)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !failed) begin
      if (head.op == dcb_pkg::OP_DRAW) begin
        res.status             <= dcb_pkg::STATUS_PACKET;
        res.pipeline           <= head.pipeline;
        res.resource           <= head.resource;
        res.packet_node        <= current_node;
        res.packet_signature   <= signature;
        res.packet_order       <= next_order;
        res.merged             <= merge_hit;
        res.batch_index        <= batches_next - 32'd1;
        res.batch_first_packet <= merge_hit ? open_first : next_order;
        res.batch_size         <= count_next;
        res.barrier_total      <= barriers;
        res.merged_total       <= merges_next;
      end else if (head.op == dcb_pkg::OP_INVALID) begin
        res <= '{status: dcb_pkg::STATUS_INVALID, default: '0};
      end
    end
  end

endmodule

[rtl/draw_command_batcher_unit.sv]
// Top level of the draw command batcher: classifier, queue and batching back end.
// Depends on dcb_pkg, dcb_front, dcb_queue and dcb_back.
//
// One item is accepted per clock while in_ready is high and at most one result comes
// out per clock; a draw item is written into the two-entry queue and then loaded
// into the result register once that register is free or being taken, and it is
// presented there until out_ready takes it. in_ready drops only when the queue is
// full, which happens only while out_ready is held low. Frame
// start, node start and state commands give no result; drawable commands give a
// packet and an undrawable command gives one error result, after which everything
// up to the next frame start is dropped. Configuration writes take effect at once
// and must be made while no item is in flight.
module draw_command_batcher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [3:0]  command_kind,
  input  logic [31:0] resource_handle,
  input  logic [31:0] node_ident,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [1:0]  pipeline,
  output logic [31:0] resource,
  output logic [31:0] packet_node,
  output logic [63:0] packet_signature,
  output logic [31:0] packet_order,
  output logic        merged,
  output logic [31:0] batch_index,
  output logic [31:0] batch_first_packet,
  output logic [15:0] batch_size,
  output logic [31:0] barrier_total,
  output logic [31:0] merged_total
);

  dcb_pkg::queue_status_t q_status;
  dcb_pkg::entry_t        q_entry;
  dcb_pkg::entry_t        q_head;
  dcb_pkg::result_t       res;
  logic                   q_push;
  logic                   q_pop;

  dcb_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .command_kind    (command_kind),
    .resource_handle (resource_handle),
    .node_ident      (node_ident),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  dcb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  dcb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (q_head),
    .q_status  (q_status),
    .pop       (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign status             = res.status;
  assign pipeline           = res.pipeline;
  assign resource           = res.resource;
  assign packet_node        = res.packet_node;
  assign packet_signature   = res.packet_signature;
  assign packet_order       = res.packet_order;
  assign merged             = res.merged;
  assign batch_index        = res.batch_index;
  assign batch_first_packet = res.batch_first_packet;
  assign batch_size         = res.batch_size;
  assign barrier_total      = res.barrier_total;
  assign merged_total       = res.merged_total;

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (pipeline == dcb_pkg::PIPE_RECT &&
                               resource == dcb_pkg::RES_FILL &&
                               batch_size == 16'd0 && !merged))
    else $error("error result carries packet fields");

  a_packet_size: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status) |-> (batch_size != 16'd0))
    else $error("packet result with empty batch");

  a_merge_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && merged) |-> (batch_size != 16'd1 && packet_order != batch_first_packet))
    else $error("merged packet does not extend an open batch");

endmodule
